[hdl/vgn_pkg.sv]
// vgn_pkg: shared constants, register indexes and the command entry type
// for the volume gradient normal block. No dependencies.
package vgn_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int SIDE_W     = 7;
	localparam int COORD_W    = 6;
	localparam int OFF_W      = 5;
	localparam int DENS_W     = 8;
	localparam int NRM_W      = 16;
	localparam int FRAC_BITS  = 14;
	localparam int ADDR_W     = 18;
	localparam int WH_W       = 13;
	localparam int WN_W       = 11;
	localparam int WHN_W      = 17;
	localparam int DIFF_W     = 9;
	localparam int SQ_W       = 16;
	localparam int SUM_W      = 18;
	localparam int Q_W        = FRAC_BITS + 1;
	localparam int TSQ_W      = 2 * Q_W;
	localparam int PROD_W     = TSQ_W + SUM_W;
	localparam int BIT_W      = 4;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_DEPTH  = 2'd2,
		CFG_OFFSET = 2'd3
	} cfg_idx_t;

	// one classified request handed from front to back
	typedef struct packed {
		logic               is_load;
		logic               err;
		logic               border;
		logic [DENS_W-1:0]  dens;
		logic [ADDR_W-1:0]  base;
		logic [OFF_W-1:0]   off_x;
		logic [WN_W-1:0]    off_y;
		logic [WHN_W-1:0]   off_z;
	} cmd_t;

endpackage

[hdl/vgn_front.sv]
// vgn_front: configuration registers, request classification and address
// generation in two stages. Depends on vgn_pkg.
module vgn_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vgn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vgn_pkg::SIDE_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_op,
	input  logic [31:0]                   in_data,
	output logic                          push,
	output vgn_pkg::cmd_t                 push_cmd,
	input  logic                          q_full
);
	logic [vgn_pkg::SIDE_W-1:0] w_q, h_q, d_q, clamped;
	logic [vgn_pkg::OFF_W-1:0]  n_q;
	logic [vgn_pkg::WH_W-1:0]   wh_q;

	logic                        valid_s1, op_s1;
	logic [vgn_pkg::COORD_W-1:0] x_s1, y_s1, z_s1;
	logic [vgn_pkg::DENS_W-1:0]  dens_s1;
	logic                        in_vol, border, adv1, adv2;

	logic                        valid_s2, op_s2, err_s2, border_s2;
	logic [vgn_pkg::DENS_W-1:0]  dens_s2;
	logic [vgn_pkg::ADDR_W-1:0]  whz_s2;
	logic [vgn_pkg::WH_W-1:0]    wy_s2;
	logic [vgn_pkg::COORD_W-1:0] x_s2;
	logic [vgn_pkg::OFF_W-1:0]   n_s2;
	logic [vgn_pkg::WN_W-1:0]    wn_s2;
	logic [vgn_pkg::WHN_W-1:0]   whn_s2;

	always_comb begin
		if (cfg_wdata == '0)
			clamped = vgn_pkg::SIDE_W'(1);
		else if (cfg_wdata > vgn_pkg::SIDE_W'(vgn_pkg::MAX_SIDE))
			clamped = vgn_pkg::SIDE_W'(vgn_pkg::MAX_SIDE);
		else
			clamped = cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= vgn_pkg::SIDE_W'(vgn_pkg::MAX_SIDE);
			h_q  <= vgn_pkg::SIDE_W'(vgn_pkg::MAX_SIDE);
			d_q  <= vgn_pkg::SIDE_W'(vgn_pkg::MAX_SIDE);
			n_q  <= vgn_pkg::OFF_W'(1);
			wh_q <= vgn_pkg::WH_W'(vgn_pkg::MAX_SIDE * vgn_pkg::MAX_SIDE);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					vgn_pkg::CFG_WIDTH:  w_q <= clamped;
					vgn_pkg::CFG_HEIGHT: h_q <= clamped;
					vgn_pkg::CFG_DEPTH:  d_q <= clamped;
					vgn_pkg::CFG_OFFSET: n_q <= cfg_wdata[vgn_pkg::OFF_W-1:0];
					default: ;
				endcase
			end
			wh_q <= vgn_pkg::WH_W'(w_q * h_q);
		end
	end

	assign adv2     = valid_s2 && !q_full;
	assign adv1     = valid_s1 && (!valid_s2 || adv2);
	assign in_ready = !valid_s1 || adv1;

	assign in_vol = ({1'b0, x_s1} < w_q) && ({1'b0, y_s1} < h_q) && ({1'b0, z_s1} < d_q);
	assign border = ({1'b0, x_s1} < {2'b0, n_q}) || ({1'b0, x_s1} + {2'b0, n_q} >= w_q)
		|| ({1'b0, y_s1} < {2'b0, n_q}) || ({1'b0, y_s1} + {2'b0, n_q} >= h_q)
		|| ({1'b0, z_s1} < {2'b0, n_q}) || ({1'b0, z_s1} + {2'b0, n_q} >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv1)
				valid_s2 <= 1'b1;
			else if (adv2)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= in_op;
			x_s1    <= in_data[5:0];
			y_s1    <= in_data[11:6];
			z_s1    <= in_data[17:12];
			dens_s1 <= in_data[25:18];
		end
		if (adv1) begin
			op_s2     <= op_s1;
			err_s2    <= !in_vol;
			border_s2 <= border;
			dens_s2   <= dens_s1;
			whz_s2    <= vgn_pkg::ADDR_W'(wh_q * z_s1);
			wy_s2     <= vgn_pkg::WH_W'(w_q * y_s1);
			x_s2      <= x_s1;
			n_s2      <= n_q;
			wn_s2     <= vgn_pkg::WN_W'(w_q * n_q);
			whn_s2    <= vgn_pkg::WHN_W'(wh_q * n_q);
		end
	end

	assign push              = adv2;
	assign push_cmd.is_load  = !op_s2;
	assign push_cmd.err      = err_s2;
	assign push_cmd.border   = border_s2;
	assign push_cmd.dens     = dens_s2;
	assign push_cmd.base     = whz_s2 + vgn_pkg::ADDR_W'(wy_s2) + vgn_pkg::ADDR_W'(x_s2);
	assign push_cmd.off_x    = n_s2;
	assign push_cmd.off_y    = wn_s2;
	assign push_cmd.off_z    = whn_s2;
endmodule

[hdl/vgn_queue.sv]
// vgn_queue: two-entry command queue between front and back.
// Depends on vgn_pkg.
module vgn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vgn_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output vgn_pkg::cmd_t head
);
	vgn_pkg::cmd_t slot_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_cmd;
	end
endmodule

[hdl/vgn_back.sv]
// vgn_back: density memory, neighbor read sequencer, bit-serial normalizer
// and result register. Depends on vgn_pkg.
module vgn_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  vgn_pkg::cmd_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [55:0]   out_data,
	output logic [1:0]    out_user
);
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_READ = 9'b000000010,
		ST_LAST = 9'b000000100,
		ST_DIFF = 9'b000001000,
		ST_SUM  = 9'b000010000,
		ST_MAG  = 9'b000100000,
		ST_SQ   = 9'b001000000,
		ST_CMP  = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [vgn_pkg::DENS_W-1:0] mem_q [vgn_pkg::MAX_SIDE*vgn_pkg::MAX_SIDE*vgn_pkg::MAX_SIDE];
	logic [vgn_pkg::DENS_W-1:0] rdata_q;
	logic [vgn_pkg::ADDR_W-1:0] raddr;

	vgn_pkg::cmd_t               cur_q;
	logic [2:0]                  rd_idx_q, cap_idx_q;
	logic                        cap_en_q;
	logic [vgn_pkg::DENS_W-1:0]  vox_q [7];
	logic signed [vgn_pkg::DIFF_W-1:0] dif_q [3];
	logic [vgn_pkg::SUM_W-1:0]   sum_q;
	logic [vgn_pkg::SQ_W-1:0]    m2_q;
	logic [1:0]                  comp_q;
	logic [vgn_pkg::BIT_W-1:0]   bit_q;
	logic [vgn_pkg::Q_W-1:0]     q_q, trial;
	logic [vgn_pkg::TSQ_W-1:0]   tsq_q;
	logic [vgn_pkg::PROD_W-1:0]  prod, limit;
	logic [vgn_pkg::NRM_W-1:0]   nrm_q [3], signed_q;
	logic signed [2*vgn_pkg::DIFF_W-1:0] sq;
	logic [vgn_pkg::Q_W-1:0]     q_next;

	assign pop = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		case (rd_idx_q)
			3'd1:    raddr = cur_q.base - vgn_pkg::ADDR_W'(cur_q.off_x);
			3'd2:    raddr = cur_q.base + vgn_pkg::ADDR_W'(cur_q.off_x);
			3'd3:    raddr = cur_q.base - vgn_pkg::ADDR_W'(cur_q.off_y);
			3'd4:    raddr = cur_q.base + vgn_pkg::ADDR_W'(cur_q.off_y);
			3'd5:    raddr = cur_q.base - vgn_pkg::ADDR_W'(cur_q.off_z);
			3'd6:    raddr = cur_q.base + vgn_pkg::ADDR_W'(cur_q.off_z);
			default: raddr = cur_q.base;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_load && !head.err)
			mem_q[head.base] <= head.dens;
		rdata_q <= mem_q[raddr];
	end

	assign trial  = q_q | (vgn_pkg::Q_W'(1) << bit_q);
	assign prod   = tsq_q * sum_q;
	assign limit  = vgn_pkg::PROD_W'({m2_q, {(2*vgn_pkg::FRAC_BITS){1'b0}}});
	assign q_next = (prod <= limit) ? trial : q_q;
	assign sq     = dif_q[comp_q] * dif_q[comp_q];

	always_comb begin
		if (dif_q[comp_q] < 0)
			signed_q = vgn_pkg::NRM_W'(-$signed({1'b0, q_next}));
		else
			signed_q = vgn_pkg::NRM_W'(q_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			cap_en_q  <= 1'b0;
		end else begin
			cap_en_q <= state_q == ST_READ;
			if (out_valid && out_ready && state_q != ST_OUT)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop && !head.is_load)
						state_q <= head.err ? ST_OUT : ST_READ;
				end
				ST_READ: begin
					if (cur_q.border || rd_idx_q == 3'd6)
						state_q <= ST_LAST;
				end
				ST_LAST: state_q <= cur_q.border ? ST_OUT : ST_DIFF;
				ST_DIFF: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_MAG;
				ST_MAG:  state_q <= (sum_q == '0) ? ST_OUT : ST_SQ;
				ST_SQ:   state_q <= ST_CMP;
				ST_CMP: begin
					if (bit_q != '0)
						state_q <= ST_SQ;
					else if (comp_q == 2'd2)
						state_q <= ST_OUT;
					else
						state_q <= ST_MAG;
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cap_en_q)
			vox_q[cap_idx_q] <= rdata_q;
		cap_idx_q <= rd_idx_q;
		case (state_q)
			ST_IDLE: begin
				cur_q    <= head;
				rd_idx_q <= '0;
				comp_q   <= '0;
				nrm_q[0] <= '0;
				nrm_q[1] <= (head.border && !head.err) ?
					vgn_pkg::NRM_W'(1 << vgn_pkg::FRAC_BITS) : '0;
				nrm_q[2] <= '0;
			end
			ST_READ: rd_idx_q <= rd_idx_q + 3'd1;
			ST_DIFF: begin
				dif_q[0] <= $signed({1'b0, vox_q[1]}) - $signed({1'b0, vox_q[2]});
				dif_q[1] <= $signed({1'b0, vox_q[3]}) - $signed({1'b0, vox_q[4]});
				dif_q[2] <= $signed({1'b0, vox_q[5]}) - $signed({1'b0, vox_q[6]});
			end
			ST_SUM: begin
				sum_q <= vgn_pkg::SUM_W'(dif_q[0] * dif_q[0])
					+ vgn_pkg::SUM_W'(dif_q[1] * dif_q[1])
					+ vgn_pkg::SUM_W'(dif_q[2] * dif_q[2]);
			end
			ST_MAG: begin
				m2_q  <= sq[vgn_pkg::SQ_W-1:0];
				q_q   <= '0;
				bit_q <= vgn_pkg::BIT_W'(vgn_pkg::FRAC_BITS);
			end
			ST_SQ: tsq_q <= trial * trial;
			ST_CMP: begin
				q_q   <= q_next;
				bit_q <= bit_q - vgn_pkg::BIT_W'(1);
				if (bit_q == '0) begin
					nrm_q[comp_q] <= signed_q;
					comp_q        <= comp_q + 2'd1;
				end
			end
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					out_data <= {(cur_q.err ? {vgn_pkg::DENS_W{1'b0}} : vox_q[0]),
						nrm_q[2], nrm_q[1], nrm_q[0]};
					out_user <= {cur_q.err, cur_q.border && !cur_q.err};
				end
			end
			default: ;
		endcase
	end
endmodule

[hdl/volume_gradient_normal.sv]
// volume_gradient_normal: top level, central-difference unit gradient of a
// density volume. Depends on vgn_pkg, vgn_front, vgn_queue, vgn_back.
//
//  channel | bus      | content
//  --------+----------+--------------------------------------------------
//  in      | s_axis_* | load or evaluate request at a voxel coordinate
//  out     | m_axis_* | density and Q1.14 unit normal per evaluate request
//  config  | cfg_*    | volume size and neighbor distance, write only
//
// a load request is written to memory as the back end pops it, after its 2 front stages
// an evaluate request makes 7 memory reads in the back end, then 15 restoring
// steps per component for 3 components, each a square state and a compare state;
// requests near the border read only the centre voxel and skip the normalization
// as do requests outside the volume; memory content is undefined after reset; no clearing pass
// the queue lets the front keep accepting while the back end is busy
module volume_gradient_normal (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // coord_x, coord_y, coord_z, density
	input  logic [0:0]                    s_axis_tuser,  // operation
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [55:0]                   m_axis_tdata,  // normal_x, normal_y, normal_z, voxel_density
	output logic [1:0]                    m_axis_tuser,  // near_border, request_error
	input  logic                          cfg_we,
	input  logic [vgn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vgn_pkg::SIDE_W-1:0]    cfg_wdata
);
	// front to queue and queue to back
	logic          push, q_full, q_empty, pop;
	vgn_pkg::cmd_t push_cmd, head;

	// classify and build addresses
	vgn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser[0]),
		.in_data   (s_axis_tdata),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	// decouples request intake from gradient evaluation
	vgn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	// memory, neighbor reads and normalization
	vgn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);
endmodule

[hdl/vgn_checker.sv]
// vgn_checker: port-level assertions for volume_gradient_normal and its bind.
// Depends on vgn_pkg.
module vgn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	localparam logic [15:0] ONE = 16'(1 << vgn_pkg::FRAC_BITS);

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// error results carry nothing else
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
		else $error("error result not cleared");

	// border results carry the default normal
	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
		m_axis_tdata[15:0] == '0 && m_axis_tdata[31:16] == ONE && m_axis_tdata[47:32] == '0)
		else $error("border normal wrong");

	// x and y components stay within unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		$signed(m_axis_tdata[15:0]) <= $signed(ONE) && $signed(m_axis_tdata[15:0]) >= -$signed(ONE)
		&& $signed(m_axis_tdata[31:16]) <= $signed(ONE)
		&& $signed(m_axis_tdata[31:16]) >= -$signed(ONE))
		else $error("normal out of range");
endmodule

bind volume_gradient_normal vgn_checker u_vgn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
